// ----- design/osg_pkg.sv -----
// shared types and constants for the outline segment generator
package osg_pkg;

  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // reciprocal of three, exact for magnitudes below 2**16
  localparam int        RECIP3_SHIFT = 17;
  localparam logic [16:0] RECIP3     = 17'd43691;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic [7:0]         border_width;
    logic [11:0]        title_height;
  } osg_in_t;

  typedef struct packed {
    logic signed [15:0] seg_x1;
    logic signed [15:0] seg_y1;
    logic signed [15:0] seg_x2;
    logic signed [15:0] seg_y2;
    logic               last_seg;
  } osg_out_t;

  // one request's work: undraw the old outline, then draw the new one
  typedef struct packed {
    osg_in_t old_rect;
    osg_in_t new_rect;
    logic    old_en;
    logic    new_en;
  } osg_job_t;

endpackage

// ----- design/osg_front.sv -----
// front end: holds the previous rectangle and classifies each request
module osg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             rect_valid,
  output logic             rect_ready,
  input  osg_pkg::osg_in_t rect,
  input  logic             q_ready,
  output logic             push,
  output osg_pkg::osg_job_t push_job
);
  import osg_pkg::*;

  osg_in_t prev;
  logic    accept;
  logic    changed;

  always_comb begin
    accept              = rect_valid && q_ready;
    changed             = rect != prev;
    push_job.old_rect   = prev;
    push_job.new_rect   = rect;
    push_job.old_en     = (prev.rect_width != '0) || (prev.rect_height != '0);
    push_job.new_en     = (rect.rect_width != '0) || (rect.rect_height != '0);
    push                = accept && changed && (push_job.old_en || push_job.new_en);
    rect_ready          = q_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (accept && changed) begin
      prev <= rect;
    end
  end

endmodule

// ----- design/osg_queue.sv -----
// small job queue between front and back
module osg_queue #(
  parameter int DEPTH = osg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  osg_pkg::osg_job_t wdata,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output osg_pkg::osg_job_t rdata
);
  import osg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  osg_job_t           mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    ready   = count != CNT_W'(DEPTH);
    valid   = count != '0;
    rdata   = mem[rptr];
    do_push = push && ready;
    do_pop  = pop && valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/osg_back.sv -----
// back end: outline geometry and segment sequencing
module osg_back #(
  parameter int COORD_BITS = osg_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_pop,
  input  osg_pkg::osg_job_t job_in,
  output logic              seg_valid,
  input  logic              seg_ready,
  output osg_pkg::osg_out_t seg
);
  import osg_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {B_IDLE, B_GEO, B_DIV, B_EMIT} state_t;

  typedef enum logic [3:0] {
    SEG_TOP, SEG_BOTTOM, SEG_LEFT, SEG_RIGHT,
    SEG_VGRID1, SEG_VGRID2, SEG_HGRID1, SEG_HGRID2, SEG_TITLE
  } seg_t;

  state_t   state;
  osg_job_t job;
  logic     phase;
  seg_t     seg_idx;

  coord_t   xl, xr, yt, yb, xil, xir, yit, yib, yth;
  coord_t   gx1, gx2, gy1, gy2;
  logic [15:0] mag_x, mag_y;
  logic     neg_x, neg_y, th_nz;

  osg_in_t  r;
  coord_t   c_x, c_y, c_w, c_h, c_bw, c_th;
  logic [17:0] dx, dy, ax, ay;
  logic [32:0] px, py;
  coord_t   qx, qy;
  coord_t   sx1, sy1, sx2, sy2;
  logic     out_free, emit, outline_done, run_last, take_job;

  function automatic logic signed [15:0] to_field(coord_t c);
    logic [31:0] t;
    t = 32'(c);
    return t[15:0];
  endfunction

  always_comb begin
    r    = phase ? job.new_rect : job.old_rect;
    c_x  = COORD_BITS'(r.pos_x);
    c_y  = COORD_BITS'(r.pos_y);
    c_w  = COORD_BITS'(r.rect_width);
    c_h  = COORD_BITS'(r.rect_height);
    c_bw = COORD_BITS'(r.border_width);
    c_th = COORD_BITS'(r.title_height);

    // exact inner spans, independent of position
    dx = 18'(r.rect_width) - 18'd1 - {9'd0, r.border_width, 1'b0};
    dy = 18'(r.rect_height) - 18'd1 - 18'(r.title_height) - {9'd0, r.border_width, 1'b0};
    ax = dx[17] ? -dx : dx;
    ay = dy[17] ? -dy : dy;

    px = 33'(mag_x) * 33'(RECIP3);
    py = 33'(mag_y) * 33'(RECIP3);
    qx = neg_x ? -COORD_BITS'(px[RECIP3_SHIFT +: 16]) : COORD_BITS'(px[RECIP3_SHIFT +: 16]);
    qy = neg_y ? -COORD_BITS'(py[RECIP3_SHIFT +: 16]) : COORD_BITS'(py[RECIP3_SHIFT +: 16]);

    out_free     = !seg_valid || seg_ready;
    emit         = (state == B_EMIT) && out_free;
    outline_done = emit && ((seg_idx == SEG_TITLE) || ((seg_idx == SEG_HGRID2) && !th_nz));
    run_last     = phase || !job.new_en;
    take_job     = job_valid && ((state == B_IDLE) || (outline_done && run_last));
    job_pop      = take_job;

    unique case (seg_idx)
      SEG_TOP:    begin sx1 = xl;  sy1 = yt;  sx2 = xr;  sy2 = yt;  end
      SEG_BOTTOM: begin sx1 = xl;  sy1 = yb;  sx2 = xr;  sy2 = yb;  end
      SEG_LEFT:   begin sx1 = xl;  sy1 = yt;  sx2 = xl;  sy2 = yb;  end
      SEG_RIGHT:  begin sx1 = xr;  sy1 = yt;  sx2 = xr;  sy2 = yb;  end
      SEG_VGRID1: begin sx1 = gx1; sy1 = yit; sx2 = gx1; sy2 = yib; end
      SEG_VGRID2: begin sx1 = gx2; sy1 = yit; sx2 = gx2; sy2 = yib; end
      SEG_HGRID1: begin sx1 = xil; sy1 = gy1; sx2 = xir; sy2 = gy1; end
      SEG_HGRID2: begin sx1 = xil; sy1 = gy2; sx2 = xir; sy2 = gy2; end
      SEG_TITLE:  begin sx1 = xl;  sy1 = yth; sx2 = xr;  sy2 = yth; end
      default:    begin sx1 = '0;  sy1 = '0;  sx2 = '0;  sy2 = '0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_GEO) begin
      xl    <= c_x;
      xr    <= c_x + c_w - COORD_BITS'(1);
      yt    <= c_y;
      yb    <= c_y + c_h - COORD_BITS'(1);
      xil   <= c_x + c_bw;
      xir   <= c_x + c_w - COORD_BITS'(1) - c_bw;
      yit   <= c_y + c_th + c_bw;
      yib   <= c_y + c_h - COORD_BITS'(1) - c_bw;
      yth   <= c_y + c_th;
      mag_x <= ax[15:0];
      mag_y <= ay[15:0];
      neg_x <= dx[17];
      neg_y <= dy[17];
      th_nz <= r.title_height != '0;
    end
    if (state == B_DIV) begin
      gx1 <= xil + qx;
      gx2 <= xil + qx + qx;
      gy1 <= yit + qy;
      gy2 <= yit + qy + qy;
    end
    if (emit) begin
      seg.seg_x1   <= to_field(sx1);
      seg.seg_y1   <= to_field(sy1);
      seg.seg_x2   <= to_field(sx2);
      seg.seg_y2   <= to_field(sy2);
      seg.last_seg <= outline_done && run_last;
    end
    if (take_job) begin
      job <= job_in;
    end

    if (rst) begin
      state     <= B_IDLE;
      phase     <= 1'b0;
      seg_idx   <= SEG_TOP;
      seg_valid <= 1'b0;
    end else begin
      if (emit) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (take_job) begin
            phase <= !job_in.old_en;
            state <= B_GEO;
          end
        end
        B_GEO: begin
          state <= B_DIV;
        end
        B_DIV: begin
          seg_idx <= SEG_TOP;
          state   <= B_EMIT;
        end
        B_EMIT: begin
          if (outline_done) begin
            if (!run_last) begin
              phase <= 1'b1;
              state <= B_GEO;
            end else if (take_job) begin
              phase <= !job_in.old_en;
              state <= B_GEO;
            end else begin
              state <= B_IDLE;
            end
          end else if (emit) begin
            seg_idx <= seg_t'(seg_idx + 4'd1);
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  a_new_phase: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE && phase) |-> job.new_en)
    else $error("new outline phase without a new outline");

  a_old_phase: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE && !phase) |-> job.old_en)
    else $error("old outline phase without an old outline");

  a_title: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && seg_idx == SEG_TITLE) |-> th_nz)
    else $error("title separator emitted with zero title height");

  a_pop: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (state == B_GEO && $past(job_in) == job))
    else $error("popped request not loaded");

endmodule

// ----- design/outline_segment_generator_unit.sv -----
// top level of the outline segment generator
//
//  channel  | dir | handshake               | payload
//  rect     | in  | rect_valid / rect_ready | osg_in_t, one rectangle
//  seg      | out | seg_valid / seg_ready   | osg_out_t, one line segment
//
// a rectangle is taken whenever the job queue has room
// each outline runs the setup states B_GEO (spans) and B_DIV (divide by three),
// then emits one segment per cycle while the seg channel is not stalled
// an unchanged rectangle, or two empty outlines, produces nothing
// reset clears the stored rectangle, the queue and the sequencer
// a stalled seg channel holds the back end; the front keeps filling the queue
module outline_segment_generator_unit #(
  parameter int COORD_BITS  = osg_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = osg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rect_valid,
  output logic              rect_ready,
  input  osg_pkg::osg_in_t  rect,
  output logic              seg_valid,
  input  logic              seg_ready,
  output osg_pkg::osg_out_t seg
);
  import osg_pkg::*;

  logic     q_ready;
  logic     push;
  osg_job_t push_job;
  logic     q_valid;
  logic     q_pop;
  osg_job_t q_job;

  osg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rect_valid (rect_valid),
    .rect_ready (rect_ready),
    .rect       (rect),
    .q_ready    (q_ready),
    .push       (push),
    .push_job   (push_job)
  );

  osg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_job)
  );

  osg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job_in    (q_job),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg       (seg)
  );

endmodule
